>>> rtl/ccfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the capture frequency color classifier.
// Used by ccfc_div and capture_frequency_color_classifier_unit; depends on nothing.

package ccfc_pkg;

  // Block constants.
  localparam int WINDOW     = 200;
  localparam int CLOCK_HZ   = 8000000;
  localparam int STAMP_BITS = 16;

  // Field widths.
  localparam int STAMP_W   = 16;
  localparam int VAL_W     = 23;
  localparam int COLOR_W   = 3;
  localparam int SERVO_W   = 8;
  localparam int CFG_NUM   = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_SEL_W = 3;

  // Ring addressing and running sum.
  localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = VAL_W + RING_AW;

  // Sample divider sizing: the dividend is CLOCK_HZ, the divisor an interval. The
  // quotient keeps at least one bit above the sample field so that saturation can be
  // seen. Two quotient bits per cycle.
  localparam int CLK_W      = $clog2(CLOCK_HZ + 1);
  localparam int DIVIDEND_W = (CLK_W > VAL_W) ? CLK_W : VAL_W + 1;
  localparam int DIV_W      = ((DIVIDEND_W + 1) / 2) * 2;
  localparam int DIVISOR_W  = STAMP_BITS;

  // Average by reciprocal multiplication: floor(sum / WINDOW) equals
  // (sum * AVG_RECIP) >> AVG_SHIFT for every SUM_W-bit sum.
  localparam int     AVG_SHIFT = SUM_W + RING_AW;
  localparam longint AVG_RECIP = ((longint'(1) << AVG_SHIFT) + longint'(WINDOW) - 1) /
                                 longint'(WINDOW);
  localparam int     RECIP_W   = $clog2(AVG_RECIP + 1);

  // Servo compare values.
  localparam logic [SERVO_W-1:0] SERVO_IDLE      = 8'd150;
  localparam logic [SERVO_W-1:0] SERVO_PICK      = 8'd80;
  localparam logic [SERVO_W-1:0] SERVO_PICK_BLUE = 8'd60;

  // Configuration register indexes.
  localparam logic [CFG_SEL_W-1:0] REG_RED_LOW     = 3'd0;
  localparam logic [CFG_SEL_W-1:0] REG_RED_HIGH    = 3'd1;
  localparam logic [CFG_SEL_W-1:0] REG_GREEN_LOW   = 3'd2;
  localparam logic [CFG_SEL_W-1:0] REG_GREEN_HIGH  = 3'd3;
  localparam logic [CFG_SEL_W-1:0] REG_BLUE_LOW    = 3'd4;
  localparam logic [CFG_SEL_W-1:0] REG_BLUE_HIGH   = 3'd5;
  localparam logic [CFG_SEL_W-1:0] REG_WHITE_ABOVE = 3'd6;
  localparam logic [CFG_SEL_W-1:0] REG_WHITE_BELOW = 3'd7;

  localparam logic [VAL_W-1:0] CFG_RESET [CFG_NUM] = '{
    23'd5900, 23'd6600, 23'd5000, 23'd5500, 23'd3500, 23'd4200, 23'd7000, 23'd2850
  };

  typedef enum logic [COLOR_W-1:0] {
    COL_NONE  = 3'd0,
    COL_RED   = 3'd1,
    COL_GREEN = 3'd2,
    COL_BLUE  = 3'd3,
    COL_WHITE = 3'd4
  } color_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_AVG,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/ccfc_div.sv
`timescale 1ns / 1ps
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on ccfc_pkg for widths and the request struct.

module ccfc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ccfc_pkg::div_req_t           req,
  output logic                         busy,
  output logic                         done,
  output logic [ccfc_pkg::DIV_W-1:0]   quotient
);
  import ccfc_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DIV_W-1:0]     quot_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W-1:0]     quot_v;
  logic [DIVISOR_W-1:0] rem_v;
  logic [DIVISOR_W:0]   shifted;

  // Two dependent shift-compare-subtract steps.
  always_comb begin
    quot_v  = quot_r;
    rem_v   = rem_r;
    shifted = '0;
    for (int i = 0; i < 2; i++) begin
      shifted = {rem_v, quot_v[DIV_W-1]};
      quot_v  = {quot_v[DIV_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        shifted   = shifted - {1'b0, dvs_r};
        quot_v[0] = 1'b1;
      end
      rem_v = shifted[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      quot_r <= quot_v;
      rem_r  <= rem_v;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quot_r;

endmodule

>>> rtl/capture_frequency_color_classifier_unit.sv
`timescale 1ns / 1ps
// Top level of the capture frequency color classifier: control, sample ring, output word.
// Depends on ccfc_pkg and instantiates ccfc_div.

// Capture stamps arrive alternately for a rising and a falling edge, starting with a
// rising edge. A rising-edge word only latches its stamp and produces nothing. A
// falling-edge word produces exactly one result word: the interval is turned into a
// frequency sample by an iterative divider that retires two quotient bits per cycle
// of the 24-bit quotient, the sample replaces the oldest entry of a 200-entry ring
// held in a single-port memory at write-back, and the running sum of the ring is
// divided by the window length in ST_AVG by multiplying it with a rounded-up
// reciprocal. The result word is loaded into the output register in ST_EMIT, and the
// input stays stalled until the sequencer is back in ST_IDLE, so a falling-edge word
// is finished before the next input word is taken; a zero interval skips the sample
// and the ring and goes straight from ST_IDLE to ST_AVG. A result that finds the
// output register still stalled holds the sequencer, and with it the input, until the
// register frees up. The average is classified into red, green or blue windows,
// overridden to white outside the white limits, and otherwise the previous color is
// held; the three servo compare values follow from the held color. The ring needs no
// clearing pass after reset: writes fill it in order, so a slot is treated as zero
// until the write pointer has wrapped once. The result sits in an output register, so
// a new input word is taken while the previous result still waits downstream.
// Configuration registers are written through a separate always-ready port and should
// only be written while the block is idle.

module capture_frequency_color_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ccfc_pkg::STAMP_W-1:0]    in_capture_time,
  // Result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ccfc_pkg::VAL_W-1:0]      out_average_frequency,
  output logic [ccfc_pkg::COLOR_W-1:0]    out_color_code,
  output logic [ccfc_pkg::SERVO_W-1:0]    out_servo_one,
  output logic [ccfc_pkg::SERVO_W-1:0]    out_servo_two,
  output logic [ccfc_pkg::SERVO_W-1:0]    out_servo_three,
  output logic                            out_zero_interval,
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccfc_pkg::VAL_W-1:0]      cfg_data
);
  import ccfc_pkg::*;

  // Control and datapath state.
  state_t                st_r, st_nxt;
  logic                  awaiting_r;
  logic [STAMP_BITS-1:0] first_stamp_r;
  logic                  zero_r;
  logic [RING_AW-1:0]    ring_pos_r;
  logic                  ring_full_r;
  logic [SUM_W-1:0]      sum_r;
  color_t                held_color_r;
  logic [VAL_W-1:0]      cfg_r [CFG_NUM];
  logic [SUM_W+RECIP_W-1:0] avg_prod_r;

  // Sample ring memory with registered read data.
  logic [VAL_W-1:0]      ring_mem [WINDOW];
  logic [VAL_W-1:0]      rdata_r;

  // Output register.
  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_avg_r;
  color_t                out_color_r;
  logic [SERVO_W-1:0]    out_servo_one_r;
  logic [SERVO_W-1:0]    out_servo_two_r;
  logic [SERVO_W-1:0]    out_servo_three_r;
  logic                  out_zero_r;

  // Combinational helpers.
  logic                  in_acc;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] interval;
  logic                  start_sample;
  div_req_t              div_req;
  logic                  div_busy;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quot;
  logic [VAL_W-1:0]      sample;
  logic [VAL_W-1:0]      old_sample;
  logic [SUM_W-1:0]      sum_upd;
  logic                  commit;
  logic [VAL_W-1:0]      avg;
  logic                  out_free;
  logic                  emit;
  color_t                color_nxt;
  logic                  cfg_wr;

  assign in_acc   = in_valid && !in_stall;
  assign stamp    = in_capture_time[STAMP_BITS-1:0];
  assign interval = stamp - first_stamp_r;

  // A falling-edge stamp with a nonzero interval starts the sample division.
  assign start_sample = in_acc && awaiting_r && (interval != '0);

  always_comb begin
    div_req.start    = start_sample;
    div_req.dividend = DIV_W'(CLOCK_HZ);
    div_req.divisor  = DIVISOR_W'(interval);
  end

  ccfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // A sample that does not fit the field saturates to its largest value.
  assign sample = (|div_quot[DIV_W-1:VAL_W]) ? '1 : div_quot[VAL_W-1:0];

  // Slots at and after the write pointer are still zero until the first wrap.
  assign old_sample = ring_full_r ? rdata_r : '0;
  assign sum_upd    = sum_r - SUM_W'(old_sample) + SUM_W'(sample);
  assign commit     = (st_r == ST_SAMPLE) && div_done;

  // The average is the running sum times the rounded-up reciprocal of the window
  // length, which is exact for every sum the ring can hold. The product is taken in
  // ST_AVG, after the sum has settled.
  always_ff @(posedge clk) begin
    if (st_r == ST_AVG) begin
      avg_prod_r <= (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(AVG_RECIP);
    end
  end

  assign avg      = avg_prod_r[AVG_SHIFT +: VAL_W];
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (st_r == ST_EMIT) && out_free;

  // Color classification with strict bounds; white overrides, otherwise hold.
  always_comb begin
    color_nxt = held_color_r;
    if (avg > cfg_r[REG_RED_LOW] && avg < cfg_r[REG_RED_HIGH]) begin
      color_nxt = COL_RED;
    end else if (avg > cfg_r[REG_GREEN_LOW] && avg < cfg_r[REG_GREEN_HIGH]) begin
      color_nxt = COL_GREEN;
    end else if (avg > cfg_r[REG_BLUE_LOW] && avg < cfg_r[REG_BLUE_HIGH]) begin
      color_nxt = COL_BLUE;
    end
    if (avg > cfg_r[REG_WHITE_ABOVE] || avg < cfg_r[REG_WHITE_BELOW]) begin
      color_nxt = COL_WHITE;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc && awaiting_r) begin
          st_nxt = (interval == '0) ? ST_AVG : ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (div_done) begin
          st_nxt = ST_AVG;
        end
      end
      ST_AVG: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (st_r != ST_IDLE);

  // Edge pairing, ring pointer, running sum and held color.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r    <= 1'b0;
      first_stamp_r <= '0;
      zero_r        <= 1'b0;
      ring_pos_r    <= '0;
      ring_full_r   <= 1'b0;
      sum_r         <= '0;
      held_color_r  <= COL_NONE;
    end else begin
      if (in_acc) begin
        awaiting_r <= !awaiting_r;
        if (!awaiting_r) begin
          first_stamp_r <= stamp;
        end else begin
          zero_r <= (interval == '0);
        end
      end
      if (commit) begin
        sum_r <= sum_upd;
        if (ring_pos_r == RING_AW'(WINDOW - 1)) begin
          ring_pos_r  <= '0;
          ring_full_r <= 1'b1;
        end else begin
          ring_pos_r <= ring_pos_r + 1'b1;
        end
      end
      if (emit) begin
        held_color_r <= color_nxt;
      end
    end
  end

  // The old slot is read when the division starts and held until write-back.
  always_ff @(posedge clk) begin
    if (commit) begin
      ring_mem[ring_pos_r] <= sample;
    end
    if (start_sample) begin
      rdata_r <= ring_mem[ring_pos_r];
    end
  end

  // Configuration registers; indexes past the last register are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_NUM));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      cfg_r[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_avg_r         <= avg;
      out_color_r       <= color_nxt;
      out_servo_one_r   <= (color_nxt == COL_RED) ? SERVO_PICK : SERVO_IDLE;
      out_servo_two_r   <= (color_nxt == COL_GREEN) ? SERVO_PICK : SERVO_IDLE;
      out_servo_three_r <= (color_nxt == COL_BLUE) ? SERVO_PICK_BLUE : SERVO_IDLE;
      out_zero_r        <= zero_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_average_frequency = out_avg_r;
  assign out_color_code        = out_color_r;
  assign out_servo_one         = out_servo_one_r;
  assign out_servo_two         = out_servo_two_r;
  assign out_servo_three       = out_servo_three_r;
  assign out_zero_interval     = out_zero_r;

`ifndef SYNTHESIS
  // The write pointer never leaves the ring.
  a_ring_pos: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ring_pos_r} < (RING_AW + 1)'(WINDOW))
    else $error("ring pointer out of range");

  // The divider is never restarted while a division is in flight.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

  // The running sum moves only when a sample is written back.
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(sum_r))
    else $error("running sum changed without a sample write");

  // The first servo picks exactly when the word reports red.
  a_servo_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_color_r == COL_RED) == (out_servo_one_r == SERVO_PICK)))
    else $error("servo one disagrees with color");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for capture_frequency_color_classifier_unit.
// It tracks its own frequency meter, sample ring and color classifier to predict each result
// word. Depends only on ccfc_pkg and the RTL.

module testbench;
  import ccfc_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 8;
  // Slowest correct word is a full falling-edge pass plus the longest sender gap and stall.
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 60;
  localparam int RANDOM_WORDS     = 730;
  localparam int MAX_REPORTS      = 10;
  localparam int STAMP_MAX        = (1 << STAMP_BITS) - 1;
  localparam int VAL_MAX          = (1 << VAL_W) - 1;
  localparam int CFG_INDEX_TOP    = (1 << CFG_IDX_W) - 1;
  // Steering never asks for a sample above this, so no single sample can pin the
  // average far above the color windows for a whole trip around the ring.
  localparam int STEER_SAMPLE_MAX = 400000;
  localparam int TARGET_MAX       = 9000;

  // How a phase of the random traffic sets up the eight limits.
  typedef enum {
    LIM_DEFAULT,
    LIM_CENTERED,
    LIM_RANDOM,
    LIM_ZERO,
    LIM_FULL,
    LIM_CORNERS
  } limit_plan_t;

  // One result word as the meter should produce it.
  typedef struct {
    logic [VAL_W-1:0]   avg;
    color_t             color;
    logic [SERVO_W-1:0] servo_one;
    logic [SERVO_W-1:0] servo_two;
    logic [SERVO_W-1:0] servo_three;
    logic               zero;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [STAMP_W-1:0]   in_capture_time;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VAL_W-1:0]     out_average_frequency;
  logic [COLOR_W-1:0]   out_color_code;
  logic [SERVO_W-1:0]   out_servo_one;
  logic [SERVO_W-1:0]   out_servo_two;
  logic [SERVO_W-1:0]   out_servo_three;
  logic                 out_zero_interval;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;

  // Mirror of the block: limits, edge phase, sample ring, running sum and held color.
  logic [VAL_W-1:0]   limits_reg [CFG_NUM];
  logic [VAL_W-1:0]   plan_limits [CFG_NUM];
  logic               awaiting_fall;
  logic [STAMP_W-1:0] rise_stamp;
  logic [VAL_W-1:0]   sample_slots [WINDOW];
  int                 slot_next;
  longint             slot_total;
  color_t             held_color;
  reading_t           pending_readings [$];
  reading_t           due_reading;

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int zero_seen    = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;
  int stall_hold   = 0;
  int color_seen [1 << COLOR_W];
  bit quiet        = 1'b0;

  capture_frequency_color_classifier_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_capture_time       (in_capture_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_average_frequency (out_average_frequency),
    .out_color_code        (out_color_code),
    .out_servo_one         (out_servo_one),
    .out_servo_two         (out_servo_two),
    .out_servo_three       (out_servo_three),
    .out_zero_interval     (out_zero_interval),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Gap lengths for both sides: mostly none or short, now and then a long one. A quiet
  // phase turns all idling off so that words also move back to back.
  function automatic int idle_length();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit between_open(input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] lo,
                                      input logic [VAL_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  function automatic logic [VAL_W-1:0] clamp_val(input longint v);
    if (v < 0) return '0;
    if (v > VAL_MAX) return VAL_MAX;
    return v[VAL_W-1:0];
  endfunction

  function automatic int meter_average();
    return int'(slot_total / WINDOW);
  endfunction

  // Picks the interval whose sample, written over the next ring slot, brings the average
  // as close to the target as a sample of at most STEER_SAMPLE_MAX can. The rising stamp
  // does not touch the ring, so the mirror is current whenever a pair starts.
  function automatic int steer_interval(input int target);
    longint need;
    longint span;
    need = longint'(target) * WINDOW - slot_total + sample_slots[slot_next];
    if (need < 1) return STAMP_MAX;
    if (need > STEER_SAMPLE_MAX) need = STEER_SAMPLE_MAX;
    span = (CLOCK_HZ + need / 2) / need;
    if (span < 1) span = 1;
    if (span > STAMP_MAX) span = STAMP_MAX;
    return int'(span);
  endfunction

  // Advances the mirror by one accepted capture word. A rising word only latches its
  // stamp; a falling word turns the interval into a sample, updates ring and sum unless
  // the interval is zero, classifies the new average and queues the reading.
  task automatic update_meter(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] span;
    logic [VAL_W-1:0]   avg;
    longint             smp;
    reading_t           r;
    if (!awaiting_fall) begin
      rise_stamp    = stamp;
      awaiting_fall = 1'b1;
      return;
    end
    awaiting_fall = 1'b0;
    span = stamp - rise_stamp;
    if (span != '0) begin
      smp = longint'(CLOCK_HZ) / longint'(span);
      if (smp > VAL_MAX) smp = VAL_MAX;
      slot_total = slot_total - sample_slots[slot_next] + smp;
      sample_slots[slot_next] = smp[VAL_W-1:0];
      slot_next = (slot_next == WINDOW - 1) ? 0 : slot_next + 1;
    end
    avg = clamp_val(slot_total / WINDOW);
    // Windows are tried in order red, green, blue; the white limits override them, and
    // when nothing matches the previous color is held.
    if (between_open(avg, limits_reg[REG_RED_LOW], limits_reg[REG_RED_HIGH])) begin
      held_color = COL_RED;
    end else if (between_open(avg, limits_reg[REG_GREEN_LOW], limits_reg[REG_GREEN_HIGH])) begin
      held_color = COL_GREEN;
    end else if (between_open(avg, limits_reg[REG_BLUE_LOW], limits_reg[REG_BLUE_HIGH])) begin
      held_color = COL_BLUE;
    end
    if (avg > limits_reg[REG_WHITE_ABOVE] || avg < limits_reg[REG_WHITE_BELOW]) begin
      held_color = COL_WHITE;
    end
    r.avg         = avg;
    r.color       = held_color;
    r.servo_one   = (held_color == COL_RED) ? SERVO_PICK : SERVO_IDLE;
    r.servo_two   = (held_color == COL_GREEN) ? SERVO_PICK : SERVO_IDLE;
    r.servo_three = (held_color == COL_BLUE) ? SERVO_PICK_BLUE : SERVO_IDLE;
    r.zero        = (span == '0);
    pending_readings.push_back(r);
  endtask

  // Offers one capture word and holds it until the block takes it. Valid stays high when
  // no gap follows, so the next word can go out on the very next edge.
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int gap;
    in_valid        <= 1'b1;
    in_capture_time <= stamp;
    do @(posedge clk); while (in_stall);
    update_meter(stamp);
    words_sent++;
    gap = idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pair(input logic [STAMP_W-1:0] rise, input int span);
    send_stamp(rise);
    send_stamp(rise + span[STAMP_W-1:0]);
  endtask

  // Stops sending and waits for every queued reading, then lets the clock run on in case the
  // last word was a rising edge that produces nothing.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write. Valid is left high when another write follows at once, so that it
  // is never dropped and raised again on the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    if (idx < CFG_NUM) limits_reg[idx] = value;
    cfg_writes++;
  endtask

  // Writes all eight planned limits, optionally after a write to an unused index that the
  // block must ignore.
  task automatic apply_limits(input bit stray);
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(CFG_NUM, CFG_INDEX_TOP)),
                VAL_W'($urandom_range(0, VAL_MAX)), 1'b1);
    end
    for (int i = 0; i < CFG_NUM; i++) begin
      write_reg(CFG_IDX_W'(i), plan_limits[i], i != CFG_NUM - 1);
    end
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic plan_phase_limits(input limit_plan_t plan);
    int a;
    int c;
    int hw;
    a = meter_average();
    case (plan)
      LIM_DEFAULT: begin
        for (int i = 0; i < CFG_NUM; i++) plan_limits[i] = CFG_RESET[i];
      end
      LIM_CENTERED: begin
        // Color windows scattered around the present average, so the next few dozen
        // readings land inside, between and right on the bounds.
        c = a + jitter(150); hw = $urandom_range(0, 120);
        plan_limits[REG_RED_LOW]     = clamp_val(c - hw);
        plan_limits[REG_RED_HIGH]    = clamp_val(c + hw);
        c = a + jitter(150); hw = $urandom_range(0, 120);
        plan_limits[REG_GREEN_LOW]   = clamp_val(c - hw);
        plan_limits[REG_GREEN_HIGH]  = clamp_val(c + hw);
        c = a + jitter(150); hw = $urandom_range(0, 120);
        plan_limits[REG_BLUE_LOW]    = clamp_val(c - hw);
        plan_limits[REG_BLUE_HIGH]   = clamp_val(c + hw);
        plan_limits[REG_WHITE_ABOVE] = clamp_val(a + int'($urandom_range(0, 600)));
        plan_limits[REG_WHITE_BELOW] = clamp_val(a - int'($urandom_range(0, 600)));
      end
      LIM_RANDOM: begin
        for (int i = 0; i < CFG_NUM; i++) plan_limits[i] = VAL_W'($urandom_range(0, VAL_MAX));
      end
      LIM_ZERO: begin
        for (int i = 0; i < CFG_NUM; i++) plan_limits[i] = '0;
      end
      LIM_FULL: begin
        for (int i = 0; i < CFG_NUM; i++) plan_limits[i] = VAL_MAX;
      end
      default: begin
        for (int i = 0; i < CFG_NUM; i++) begin
          plan_limits[i] = $urandom_range(0, 1) ? VAL_W'(VAL_MAX) : '0;
        end
      end
    endcase
  endtask

  // Straight after reset nothing has been classified yet. With the lower white limit at
  // zero an average of zero matches nothing, so the color stays none and all servos idle.
  task automatic test_no_color();
    write_reg(CFG_IDX_W'(REG_WHITE_BELOW), '0, 1'b0);
    send_pair(16'h0000, STAMP_MAX);
    send_pair(16'hFFFF, 0);
    wait_results_done();
    write_reg(CFG_IDX_W'(REG_WHITE_BELOW), CFG_RESET[REG_WHITE_BELOW], 1'b0);
  endtask

  // Reset limits: the average is walked upward through white-below, blue, the gap between
  // blue and green (color held), green, red and white-above. The red pair wraps the timer.
  // A zero interval at the end must keep the ring and report the held color.
  task automatic test_color_windows();
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)),
              steer_interval(CFG_RESET[REG_WHITE_BELOW] - 500));
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)),
              steer_interval((CFG_RESET[REG_BLUE_LOW] + CFG_RESET[REG_BLUE_HIGH]) / 2));
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)),
              steer_interval((CFG_RESET[REG_BLUE_HIGH] + CFG_RESET[REG_GREEN_LOW]) / 2));
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)),
              steer_interval((CFG_RESET[REG_GREEN_LOW] + CFG_RESET[REG_GREEN_HIGH]) / 2));
    send_pair(16'hFFF0,
              steer_interval((CFG_RESET[REG_RED_LOW] + CFG_RESET[REG_RED_HIGH]) / 2));
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)),
              steer_interval(CFG_RESET[REG_WHITE_ABOVE] + 500));
    send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)), 0);
  endtask

  // Phases of random traffic, each under a fresh set of limits written while the block is
  // idle. The first two phases use the all-zero and all-ones extremes. Most pairs steer
  // the average toward a limit or a random level; the rest are zero intervals and pairs
  // with arbitrary intervals.
  task automatic test_random_traffic();
    int          goal;
    int          phase;
    int          pick;
    int          target;
    int          span;
    limit_plan_t plan;
    goal  = words_sent + RANDOM_WORDS;
    phase = 0;
    while (words_sent < goal) begin
      wait_results_done();
      if (phase == 0) plan = LIM_ZERO;
      else if (phase == 1) plan = LIM_FULL;
      else begin
        pick = $urandom_range(0, 9);
        plan = (pick < 2) ? LIM_DEFAULT : (pick < 7) ? LIM_CENTERED :
               (pick < 9) ? LIM_RANDOM : LIM_CORNERS;
      end
      plan_phase_limits(plan);
      apply_limits(phase < 2 || $urandom_range(0, 1));
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 29) == 0) wait_results_done();
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          if ($urandom_range(0, 1)) begin
            target = int'(limits_reg[$urandom_range(0, CFG_NUM - 1)]) + jitter(3);
          end else begin
            target = $urandom_range(0, TARGET_MAX);
          end
          if (target < 0) target = 0;
          if (target > TARGET_MAX) target = TARGET_MAX;
          span = steer_interval(target);
        end else if (pick < 75) begin
          span = 0;
        end else begin
          span = $urandom_range(20, STAMP_MAX);
        end
        send_pair(STAMP_W'($urandom_range(0, STAMP_MAX)), span);
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // Interval of one tick, which wraps the timer and gives the largest possible sample,
  // the longest interval, and a zero interval. Run last: the large sample would hold the
  // average far above every window for a full trip around the ring.
  task automatic test_interval_extremes();
    wait_results_done();
    plan_phase_limits(LIM_DEFAULT);
    apply_limits(1'b0);
    send_pair(16'hFFFF, 1);
    send_pair(16'h0000, STAMP_MAX);
    send_pair(16'h8000, 0);
  endtask

  // The receiver stalls in bursts whose lengths come from the same spread as the sender's
  // gaps, with runs of free cycles in between; a quiet phase never stalls.
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold = idle_length();
    end else begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 12);
    end
  end

  // Each accepted result word is compared with the oldest queued reading.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected result word avg=%0d color=%0d zero=%0b",
                   out_average_frequency, out_color_code, out_zero_interval);
        end
      end else begin
        due_reading = pending_readings.pop_front();
        results_seen++;
        color_seen[due_reading.color]++;
        if (due_reading.zero) zero_seen++;
        if (out_average_frequency !== due_reading.avg ||
            out_color_code !== due_reading.color ||
            out_servo_one !== due_reading.servo_one ||
            out_servo_two !== due_reading.servo_two ||
            out_servo_three !== due_reading.servo_three ||
            out_zero_interval !== due_reading.zero) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d: avg %0d/%0d color %0d/%0d servos %0d,%0d,%0d/%0d,%0d,%0d zero %0b/%0b (expected/actual)",
                     results_seen, due_reading.avg, out_average_frequency,
                     due_reading.color, out_color_code, due_reading.servo_one,
                     due_reading.servo_two, due_reading.servo_three, out_servo_one,
                     out_servo_two, out_servo_three, due_reading.zero, out_zero_interval);
          end
        end
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_capture_time <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    // The mirror starts from the reset state: reset limits, awaiting a rising edge,
    // a zero-cleared ring and no color.
    for (int i = 0; i < CFG_NUM; i++) limits_reg[i] = CFG_RESET[i];
    for (int i = 0; i < WINDOW; i++) sample_slots[i] = '0;
    for (int i = 0; i < (1 << COLOR_W); i++) color_seen[i] = 0;
    awaiting_fall = 1'b0;
    rise_stamp    = '0;
    slot_next     = 0;
    slot_total    = 0;
    held_color    = COL_NONE;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_no_color();
    test_color_windows();
    test_random_traffic();
    test_interval_extremes();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d capture words, %0d result words (%0d with a zero interval), %0d register writes.",
             words_sent, results_seen, zero_seen, cfg_writes);
    $display("Held colors reported: none %0d, red %0d, green %0d, blue %0d, white %0d; mismatches %0d.",
             color_seen[COL_NONE], color_seen[COL_RED], color_seen[COL_GREEN],
             color_seen[COL_BLUE], color_seen[COL_WHITE], mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
